@@ src/lfvr_pkg.sv @@
// shared constants and the cordic arctangent table for the vector rotation block
// no dependencies
`default_nettype none
package lfvr_pkg;

    localparam int COMPONENT_WIDTH_DEF = 32;
    localparam int ANGLE_WIDTH_DEF     = 16;
    localparam int CORDIC_STEPS        = 30;
    localparam int TRIG_W              = 34;
    localparam logic signed [TRIG_W-1:0] CORDIC_START = 34'sd652032874;
    localparam logic signed [TRIG_W-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [TRIG_W-1:0] HALF_TURN    = 34'sd2147483648;

    typedef logic signed [TRIG_W-1:0] trig_t;

    typedef enum logic {
        MODE_TO_GLOBAL = 1'b0,
        MODE_TO_LOCAL  = 1'b1
    } mode_t;

    // arctangent of 2^-i in 32-bit binary angle units
    function automatic trig_t atan_entry(input logic [4:0] idx);
        trig_t r;
        r = '0;
        case (idx)
            5'd0:  r = 34'sh20000000;
            5'd1:  r = 34'sh12E4051E;
            5'd2:  r = 34'sh09FB385B;
            5'd3:  r = 34'sh051111D4;
            5'd4:  r = 34'sh028B0D43;
            5'd5:  r = 34'sh0145D7E1;
            5'd6:  r = 34'sh00A2F61E;
            5'd7:  r = 34'sh00517C55;
            5'd8:  r = 34'sh0028BE53;
            5'd9:  r = 34'sh00145F2F;
            5'd10: r = 34'sh000A2F98;
            5'd11: r = 34'sh000517CC;
            5'd12: r = 34'sh00028BE6;
            5'd13: r = 34'sh000145F3;
            5'd14: r = 34'sh0000A2FA;
            5'd15: r = 34'sh0000517D;
            5'd16: r = 34'sh000028BE;
            5'd17: r = 34'sh0000145F;
            5'd18: r = 34'sh00000A30;
            5'd19: r = 34'sh00000518;
            5'd20: r = 34'sh0000028C;
            5'd21: r = 34'sh00000146;
            5'd22: r = 34'sh000000A3;
            5'd23: r = 34'sh00000051;
            5'd24: r = 34'sh00000029;
            5'd25: r = 34'sh00000014;
            5'd26: r = 34'sh0000000A;
            5'd27: r = 34'sh00000005;
            5'd28: r = 34'sh00000003;
            5'd29: r = 34'sh00000001;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ src/lfvr_cordic.sv @@
// pipelined sine/cosine cordic, one step per register stage, q4.30 outputs
// depends on lfvr_pkg
`default_nettype none
module lfvr_cordic #(
    parameter int ANGLE_WIDTH = lfvr_pkg::ANGLE_WIDTH_DEF
) (
    input  wire                             clk,
    input  wire        [ANGLE_WIDTH-1:0]    angle,
    output lfvr_pkg::trig_t                 sin_out,
    output lfvr_pkg::trig_t                 cos_out
);
    localparam int N = lfvr_pkg::CORDIC_STEPS;
    localparam int W = lfvr_pkg::TRIG_W;

    lfvr_pkg::trig_t x_reg [N+1];
    lfvr_pkg::trig_t y_reg [N+1];
    lfvr_pkg::trig_t z_reg [N+1];
    logic            flip_reg [N+1];

    logic [31:0]     a32;
    lfvr_pkg::trig_t z0;
    lfvr_pkg::trig_t z_next;
    logic            flip_next;

    // widen to a 32-bit binary angle and fold into +-pi/2
    always_comb
    begin
        a32 = {angle, {(32-ANGLE_WIDTH){1'b0}}};
        z0  = W'(signed'(a32));
        z_next    = z0;
        flip_next = 1'b0;
        if (z0 > lfvr_pkg::QUARTER_TURN)
        begin
            z_next    = z0 - lfvr_pkg::HALF_TURN;
            flip_next = 1'b1;
        end
        else if (z0 < -lfvr_pkg::QUARTER_TURN)
        begin
            z_next    = z0 + lfvr_pkg::HALF_TURN;
            flip_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= lfvr_pkg::CORDIC_START;
        y_reg[0]    <= '0;
        z_reg[0]    <= z_next;
        flip_reg[0] <= flip_next;
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < N; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            flip_reg[i+1] <= flip_reg[i];
            if (!z_reg[i][W-1])
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - lfvr_pkg::atan_entry(5'(i));
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + lfvr_pkg::atan_entry(5'(i));
            end
        end
    end

    assign sin_out = flip_reg[N] ? -y_reg[N] : y_reg[N];
    assign cos_out = flip_reg[N] ? -x_reg[N] : x_reg[N];
endmodule
`default_nettype wire

@@ src/local_frame_vector_rotation.sv @@
// top level: enu / global frame rotation of a three-component vector
// depends on lfvr_pkg and lfvr_cordic
//
//  channel   handshake        payload
//  input     start / busy     mode, vec_u, vec_v, vec_w, lon_angle, lat_angle
//  result    done (strobe)    res_u, res_v, res_w, saturated
//
// one item per cycle; the delay is set by the cordic stages plus stages a to g
// busy is never raised, results leave on a one-cycle done strobe
// reset clears only the valid line; payload registers float
`default_nettype none
module local_frame_vector_rotation #(
    parameter int COMPONENT_WIDTH = lfvr_pkg::COMPONENT_WIDTH_DEF,
    parameter int ANGLE_WIDTH     = lfvr_pkg::ANGLE_WIDTH_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               start,
    output logic                              busy,
    input  wire                               mode,
    input  wire  signed [COMPONENT_WIDTH-1:0] vec_u,
    input  wire  signed [COMPONENT_WIDTH-1:0] vec_v,
    input  wire  signed [COMPONENT_WIDTH-1:0] vec_w,
    input  wire  signed [ANGLE_WIDTH-1:0]     lon_angle,
    input  wire  signed [ANGLE_WIDTH-1:0]     lat_angle,
    output logic                              done,
    output logic signed [COMPONENT_WIDTH-1:0] res_u,
    output logic signed [COMPONENT_WIDTH-1:0] res_v,
    output logic signed [COMPONENT_WIDTH-1:0] res_w,
    output logic                              saturated
);
    localparam int CL  = lfvr_pkg::CORDIC_STEPS;  // cordic step count
    localparam int LAT = CL + 7;
    localparam int TW  = lfvr_pkg::TRIG_W;
    localparam int CW  = COMPONENT_WIDTH;
    localparam int PW  = CW + TW;          // one product
    localparam int SW  = PW + 2;           // sum of three

    typedef logic signed [TW-1:0] trig_t;

    // valid line and payload delay
    logic           vld_reg [LAT+1];
    logic           mode_reg [CL+1];
    logic signed [CW-1:0] vu_reg [CL+1];
    logic signed [CW-1:0] vv_reg [CL+1];
    logic signed [CW-1:0] vw_reg [CL+1];

    trig_t s_lon, c_lon, s_lat, c_lat;

    lfvr_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_lon (
        .clk(clk), .angle(lon_angle), .sin_out(s_lon), .cos_out(c_lon));
    lfvr_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_lat (
        .clk(clk), .angle(lat_angle), .sin_out(s_lat), .cos_out(c_lat));

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= LAT; i++)
                vld_reg[i] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= start && !busy;
            for (int i = 1; i <= LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg[0] <= mode;
        vu_reg[0]   <= vec_u;
        vv_reg[0]   <= vec_v;
        vw_reg[0]   <= vec_w;
        for (int i = 1; i <= CL; i++)
        begin
            mode_reg[i] <= mode_reg[i-1];
            vu_reg[i]   <= vu_reg[i-1];
            vv_reg[i]   <= vv_reg[i-1];
            vw_reg[i]   <= vw_reg[i-1];
        end
    end

    // stage a: register trig values aligned with the vector
    trig_t sa_lon_reg, ca_lon_reg, sa_lat_reg, ca_lat_reg;
    logic  ma_reg;
    logic signed [CW-1:0] va_reg [3];
    always_ff @(posedge clk)
    begin
        sa_lon_reg <= s_lon;
        ca_lon_reg <= c_lon;
        sa_lat_reg <= s_lat;
        ca_lat_reg <= c_lat;
        ma_reg     <= mode_reg[CL];
        va_reg[0]  <= vu_reg[CL];
        va_reg[1]  <= vv_reg[CL];
        va_reg[2]  <= vw_reg[CL];
    end

    // stage b: trig products at full width, rounded to q4.30 in stage c
    logic signed [2*TW-1:0] p_slcl, p_slsl, p_clcl, p_clsl;
    assign p_slcl = sa_lat_reg * ca_lon_reg;
    assign p_slsl = sa_lat_reg * sa_lon_reg;
    assign p_clcl = ca_lat_reg * ca_lon_reg;
    assign p_clsl = ca_lat_reg * sa_lon_reg;

    logic signed [2*TW-1:0] pb_reg [4];
    trig_t sb_lon_reg, cb_lon_reg, sb_lat_reg, cb_lat_reg;
    logic  mb_reg;
    logic signed [CW-1:0] vb_reg [3];
    always_ff @(posedge clk)
    begin
        pb_reg[0] <= p_slcl;
        pb_reg[1] <= p_slsl;
        pb_reg[2] <= p_clcl;
        pb_reg[3] <= p_clsl;
        sb_lon_reg <= sa_lon_reg;
        cb_lon_reg <= ca_lon_reg;
        sb_lat_reg <= sa_lat_reg;
        cb_lat_reg <= ca_lat_reg;
        mb_reg <= ma_reg;
        vb_reg <= va_reg;
    end

    function automatic trig_t rnd_q30(input logic signed [2*TW-1:0] p);
        logic signed [2*TW-1:0] t;
        t = (p + (2*TW)'(64'sd1 <<< 29)) >>> 30;
        return t[TW-1:0];
    endfunction

    // stage c: matrix, selected by direction
    trig_t m_mat [3][3];
    always_comb
    begin
        m_mat[0][0] = -sb_lon_reg;
        m_mat[0][1] = -rnd_q30(pb_reg[0]);
        m_mat[0][2] = rnd_q30(pb_reg[2]);
        m_mat[1][0] = cb_lon_reg;
        m_mat[1][1] = -rnd_q30(pb_reg[1]);
        m_mat[1][2] = rnd_q30(pb_reg[3]);
        m_mat[2][0] = '0;
        m_mat[2][1] = cb_lat_reg;
        m_mat[2][2] = sb_lat_reg;
    end

    trig_t kc_reg [3][3];
    logic signed [CW-1:0] vc_reg [3];
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                kc_reg[i][j] <= (mb_reg == lfvr_pkg::MODE_TO_LOCAL) ? m_mat[j][i]
                                                                    : m_mat[i][j];
        vc_reg <= vb_reg;
    end

    // stage d: nine products
    logic signed [PW-1:0] pd_reg [3][3];
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                pd_reg[i][j] <= PW'(kc_reg[i][j]) * PW'(vc_reg[j]);
    end

    // stage e: sums of three
    logic signed [SW-1:0] se_reg [3];
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            se_reg[i] <= SW'(pd_reg[i][0]) + SW'(pd_reg[i][1]) + SW'(pd_reg[i][2]);
    end

    // stage f: round
    logic signed [SW-1:0] rf_reg [3];
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            rf_reg[i] <= (se_reg[i] + SW'(64'sd1 <<< 29)) >>> 30;
    end

    // stage g: saturate and drive the result
    localparam logic signed [SW-1:0] HI = SW'((65'sd1 <<< (CW-1)) - 65'sd1);
    localparam logic signed [SW-1:0] LO = -SW'(65'sd1 <<< (CW-1));
    logic signed [CW-1:0] sat_val [3];
    logic [2:0]           clip;
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            clip[i] = 1'b0;
            sat_val[i] = rf_reg[i][CW-1:0];
            if (rf_reg[i] > HI)
            begin
                sat_val[i] = HI[CW-1:0];
                clip[i] = 1'b1;
            end
            else if (rf_reg[i] < LO)
            begin
                sat_val[i] = LO[CW-1:0];
                clip[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_u     <= sat_val[0];
        res_v     <= sat_val[1];
        res_w     <= sat_val[2];
        saturated <= |clip;
    end

    assign done = vld_reg[LAT];

    // checks
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> ##(LAT) done)
        else $error("result strobe lost");
    a_nobusy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |-> (res_u == HI[CW-1:0] || res_u == LO[CW-1:0]
        || res_v == HI[CW-1:0] || res_v == LO[CW-1:0]
        || res_w == HI[CW-1:0] || res_w == LO[CW-1:0]))
        else $error("saturation flag inconsistent");
endmodule
`default_nettype wire
